/* src/ssm_pkg.sv */
// Package for the spectral subtraction mask block: payload types, the
// controller/datapath command and status structs, defaults and widths.
// No dependencies; the top, ssm_dp, ssm_ctrl and the testbench import it.
package ssm_pkg;

  localparam int NUM_BINS_DEF   = 1024;
  localparam int MAX_SMOOTH_DEF = 33;
  localparam int MAG_WIDTH_DEF  = 24;

  localparam int ALPHA_W = 19;   // 65536 + 3 * amount, amount up to 17 bits
  localparam int GAIN_W  = 16;
  localparam int BIN_W   = 10;
  localparam int FC_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0] UNITY     = 16'h8000;
  localparam logic [10:0]       WIN_LIMIT = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE = 2'd3;

  typedef struct packed {
    logic [23:0] magnitude;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [BIN_W-1:0]  bin_index;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic upd;
    logic gdiv_start;
    logic gain_wr;
    logic em_init;
    logic sum_acc;
    logic sdiv_start;
    logic out_load;
    logic q_inc;
    logic advance;
  } ssm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic has_emit;
    logic sum_last;
    logic q_last;
    logic obuf_free;
  } ssm_sts_t;

endpackage

/* src/spectral_subtraction_mask.sv */
// A bin that yields no gain passes the memory update and one division; each gain it
// yields adds a summation over the n bins averaged from the gain ring and a second
// division in the serial 16-step divider. One bin is in work at a time.
// Reset: synchronous, active low; afterwards a clearing pass over every entry
// fills the minimum and floor memories, and no bin is taken until it ends.
// Configuration writes are always taken, clearing pass included.
module spectral_subtraction_mask
  import ssm_pkg::*;
#(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int MAX_SMOOTH = MAX_SMOOTH_DEF,
  parameter int MAG_WIDTH  = MAG_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The controller walks each bin through the memory update, the gain
  // division and then, for every gain the bin releases, a summation over the
  // gain ring followed by the averaging division. The output register lets
  // the controller go back for the next bin while a result still waits.
  ssm_cmd_t cmd;
  ssm_sts_t sts;

  // Registers are written whenever a transfer is offered.
  assign cfg_ready = 1'b1;

  ssm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  ssm_dp #(
    .NUM_BINS(NUM_BINS), .MAX_SMOOTH(MAX_SMOOTH), .MAG_WIDTH(MAG_WIDTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_we(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // A smoothed gain is an average of raw gains and can never exceed unity.
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.gain <= UNITY)
    else $error("gain above unity");

  // The controller loads a result only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.obuf_free)
    else $error("result loaded over a pending transfer");

  // A division is never started while another one reports completion.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.gdiv_start || cmd.sdiv_start) |-> !sts.div_done)
    else $error("divider restarted at completion");

endmodule

/* src/ssm_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// Uses no package.
module ssm_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ssm_div.sv */
// Restoring divider, one quotient bit per cycle, with an overflow flag for
// quotients that do not fit. Depends on nothing but its parameters.
module ssm_div #(
  parameter int NW = 44,
  parameter int DW = 25,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] rem_r, dsh_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r, ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(QW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= NW'(den) << (QW - 1);
      quo_r <= '0;
      ovf_r <= num >= (NW'(den) << QW);
    end else if (run_r) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quo  = quo_r;
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

/* src/ssm_dp.sv */
// Datapath of the spectral subtraction mask: configuration registers, the
// per-bin minimum and floor memories, the gain ring, divider and output register.
// Depends on ssm_pkg, ssm_ram and ssm_div.
module ssm_dp
  import ssm_pkg::*;
#(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int MAX_SMOOTH = MAX_SMOOTH_DEF,
  parameter int MAG_WIDTH  = MAG_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssm_cmd_t              cmd,
  output ssm_sts_t              sts,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int PW       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int RING_LEN = (MAX_SMOOTH / 2) * 2 + 1;
  localparam int RW       = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
  localparam int HW       = (MAX_SMOOTH / 2 > 0) ? $clog2(MAX_SMOOTH / 2 + 1) : 1;
  localparam int CW       = $clog2(RING_LEN + 1);
  localparam int XW       = PW + HW + 1;
  localparam int SUM_W    = GAIN_W + CW;
  localparam int NW       = ALPHA_W + MAG_WIDTH + 1;
  localparam int DW       = MAG_WIDTH + 1;
  localparam int SW       = (MAG_WIDTH > 24) ? MAG_WIDTH : 24;

  // Configuration registers.
  logic [16:0] amount_r;
  logic [10:0] window_r;
  logic [5:0]  smooth_r;
  logic [23:0] silence_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r  <= 17'd32768;
      window_r  <= 11'd141;
      smooth_r  <= 6'd9;
      silence_r <= 24'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMOUNT:  amount_r  <= cfg_data[16:0];
        REG_WINDOW:  window_r  <= cfg_data[10:0];
        REG_SMOOTH:  smooth_r  <= cfg_data[5:0];
        REG_SILENCE: silence_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [PW-1:0]   pos_r, clr_r, q_r;
  logic [RW-1:0]   rp_r, idx_r;
  logic [FC_W-1:0] fc_r;
  logic [HW-1:0]   h_r;
  logic [CW-1:0]   cnt_r, k_r;
  logic            out_valid_r;

  // Payload registers.
  logic [MAG_WIDTH-1:0]         mag_r;
  logic                         last_r, end_r, refresh_r, silent_r;
  logic [ALPHA_W+MAG_WIDTH-1:0] prod_r;
  logic [SUM_W-1:0]             sum_r;
  out_item_t                    out_r;

  // Memories.
  logic                 min_we, flr_we, ring_we;
  logic [PW-1:0]        mem_waddr;
  logic [MAG_WIDTH-1:0] min_wdata, flr_wdata, min_rd, flr_rd;
  logic [GAIN_W-1:0]    ring_wdata, ring_rd;

  ssm_ram #(.W(MAG_WIDTH), .D(NUM_BINS)) u_min_ram (
    .clk(clk), .we(min_we), .waddr(mem_waddr), .wdata(min_wdata),
    .raddr(pos_r), .rdata(min_rd)
  );

  ssm_ram #(.W(MAG_WIDTH), .D(NUM_BINS)) u_floor_ram (
    .clk(clk), .we(flr_we), .waddr(mem_waddr), .wdata(flr_wdata),
    .raddr(pos_r), .rdata(flr_rd)
  );

  ssm_ram #(.W(GAIN_W), .D(RING_LEN)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(rp_r), .wdata(ring_wdata),
    .raddr(idx_r), .rdata(ring_rd)
  );

  // Divider shared by the raw gain and the smoothing average.
  logic [NW-1:0]     div_num;
  logic [DW-1:0]     div_den;
  logic [GAIN_W-1:0] div_quo;
  logic              div_ovf, div_done;

  ssm_div #(.NW(NW), .DW(DW), .QW(GAIN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.gdiv_start | cmd.sdiv_start),
    .num(div_num), .den(div_den), .quo(div_quo), .ovf(div_ovf), .done(div_done)
  );

  // Combinational helpers.
  logic [MAG_WIDTH-1:0] m_min, flr_use;
  logic [ALPHA_W-1:0]   alpha;
  logic [10:0]          wf;
  logic                 refresh, end_now, p_ge_h, q_ge_h;
  logic [XW-1:0]        p_x, h_x, q_x, qs_x, lo_x;
  logic [5:0]           w_clip;
  logic [GAIN_W-1:0]    gain_raw;

  always_comb begin
    m_min   = (min_rd < mag_r) ? min_rd : mag_r;
    wf      = (window_r > WIN_LIMIT) ? WIN_LIMIT : window_r;
    refresh = (12'(fc_r) + 12'd1) >= 12'(wf);
    flr_use = refresh ? m_min : flr_rd;
    alpha   = ALPHA_W'(17'h10000) + ALPHA_W'({amount_r, 1'b0}) + ALPHA_W'(amount_r);
    end_now = last_r || (pos_r == PW'(NUM_BINS - 1));
    w_clip  = (smooth_r > 6'(MAX_SMOOTH)) ? 6'(MAX_SMOOTH) : smooth_r;

    p_x    = XW'(pos_r);
    h_x    = XW'(h_r);
    q_x    = XW'(q_r);
    p_ge_h = p_x >= h_x;
    q_ge_h = q_x >= h_x;
    qs_x   = p_ge_h ? (p_x - h_x) : '0;
    lo_x   = q_ge_h ? (q_x - h_x) : '0;

    gain_raw = (silent_r || div_ovf || div_quo[GAIN_W-1]) ? '0 : (UNITY - div_quo);

    if (cmd.gdiv_start) begin
      div_num = NW'(prod_r) + NW'(mag_r);
      div_den = {mag_r, 1'b0};
    end else begin
      div_num = NW'(sum_r) + NW'(cnt_r >> 1);
      div_den = DW'(cnt_r);
    end

    min_we     = cmd.clear | cmd.upd;
    flr_we     = cmd.clear | (cmd.upd & refresh);
    mem_waddr  = cmd.clear ? clr_r : pos_r;
    min_wdata  = cmd.clear ? {MAG_WIDTH{1'b1}} : (refresh ? mag_r : m_min);
    flr_wdata  = cmd.clear ? '0 : m_min;
    ring_we    = cmd.gain_wr;
    ring_wdata = gain_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      clr_r       <= '0;
      rp_r        <= '0;
      fc_r        <= '0;
      h_r         <= '0;
      q_r         <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.accept && pos_r == '0) begin
        h_r <= HW'(w_clip >> 1);
      end
      if (cmd.gain_wr) begin
        q_r <= PW'(qs_x);
      end
      if (cmd.q_inc) begin
        q_r <= q_r + 1'b1;
      end
      if (cmd.em_init) begin
        cnt_r <= CW'(p_x - lo_x) + CW'(1);
        k_r   <= CW'(p_x - lo_x) + CW'(1);
        idx_r <= rp_r;
      end
      if (cmd.sum_acc) begin
        k_r   <= k_r - 1'b1;
        idx_r <= (idx_r == '0) ? RW'(RING_LEN - 1) : idx_r - 1'b1;
      end
      if (cmd.advance) begin
        if (end_r) begin
          pos_r <= '0;
          rp_r  <= '0;
          fc_r  <= refresh_r ? '0 : fc_r + 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
          rp_r  <= (rp_r == RW'(RING_LEN - 1)) ? '0 : rp_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_r  <= MAG_WIDTH'(in_data.magnitude);
      last_r <= in_data.last_bin;
    end
    if (cmd.upd) begin
      prod_r    <= alpha * flr_use;
      refresh_r <= refresh;
      end_r     <= end_now;
      silent_r  <= (mag_r == '0) || (SW'(mag_r) < SW'(silence_r));
    end
    if (cmd.em_init) begin
      sum_r <= '0;
    end
    if (cmd.sum_acc) begin
      sum_r <= sum_r + SUM_W'(ring_rd);
    end
    if (cmd.out_load) begin
      out_r.gain      <= div_quo;
      out_r.bin_index <= BIN_W'(q_r);
      out_r.frame_end <= end_r && (q_r == pos_r);
    end
  end

  always_comb begin
    sts.clr_last  = clr_r == PW'(NUM_BINS - 1);
    sts.div_done  = div_done;
    sts.has_emit  = end_r || p_ge_h;
    sts.sum_last  = k_r == CW'(1);
    sts.q_last    = !end_r || (q_r == pos_r);
    sts.obuf_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/ssm_ctrl.sv */
// Controller state machine of the spectral subtraction mask; sequences the
// datapath through commands and reacts to its status. Depends on ssm_pkg.
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ssm_sts_t sts,
  output ssm_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_GST   = 4'd4;
  localparam logic [3:0] S_GWAIT = 4'd5;
  localparam logic [3:0] S_GWR   = 4'd6;
  localparam logic [3:0] S_EINIT = 4'd7;
  localparam logic [3:0] S_SUMA  = 4'd8;
  localparam logic [3:0] S_SUMB  = 4'd9;
  localparam logic [3:0] S_SST   = 4'd10;
  localparam logic [3:0] S_SWAIT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_ADV   = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_GST;
      end
      S_GST: begin
        cmd.gdiv_start = 1'b1;
        state_nxt      = S_GWAIT;
      end
      S_GWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_GWR;
        end
      end
      S_GWR: begin
        cmd.gain_wr = 1'b1;
        state_nxt   = sts.has_emit ? S_EINIT : S_ADV;
      end
      S_EINIT: begin
        cmd.em_init = 1'b1;
        state_nxt   = S_SUMA;
      end
      S_SUMA: state_nxt = S_SUMB;
      S_SUMB: begin
        cmd.sum_acc = 1'b1;
        state_nxt   = sts.sum_last ? S_SST : S_SUMA;
      end
      S_SST: begin
        cmd.sdiv_start = 1'b1;
        state_nxt      = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.obuf_free) begin
          cmd.out_load = 1'b1;
          if (sts.q_last) begin
            state_nxt = S_ADV;
          end else begin
            cmd.q_inc = 1'b1;
            state_nxt = S_EINIT;
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

/* sim/testbench.sv */
// Testbench for spectral_subtraction_mask: a directed table, then random frames
// in several register settings, each gain checked against an in-bench predictor.
// Depends on ssm_pkg and spectral_subtraction_mask from src.
module testbench;
  import ssm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS = 1024;
  localparam int RING = 33;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spectral_subtraction_mask dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Register shadows, with their reset values.
  int unsigned amount_r = 32768;
  int unsigned window_r = 141;
  int unsigned smooth_r = 9;
  int unsigned silence_r = 1;

  // Predictor state: per-bin minimum and noise floor, frame and bin counters,
  // the ring of raw gains and the half width latched at each frame start.
  logic [23:0] min_mem [BINS];
  logic [23:0] floor_mem [BINS];
  int unsigned frame_cnt = 0;
  int unsigned bin_pos = 0;
  logic [15:0] raw_ring [RING];
  int unsigned half_w = 0;

  out_item_t pending_gains[$];
  int errors = 0;
  bit calm = 0;  // when set, neither side inserts idle cycles

  initial begin
    for (int i = 0; i < BINS; i++) begin
      min_mem[i] = '1;
      floor_mem[i] = '0;
    end
    for (int i = 0; i < RING; i++) raw_ring[i] = '0;
  end

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Raw suppression gain: 1 - alpha*floor/mag in Q1.15, rounded half up,
  // clipped at zero; silent or zero bins get no gain at all.
  function automatic logic [15:0] raw_gain(longint unsigned mag, longint unsigned flr);
    longint unsigned alpha;
    longint unsigned sub;
    if (mag == 0 || mag < silence_r) return 16'd0;
    alpha = 65536 + 3 * longint'(amount_r);
    sub = (alpha * flr + mag) / (2 * mag);
    if (sub >= 32768) return 16'd0;
    return 16'(32768 - sub);
  endfunction

  // Queue the smoothed gain of bin q, averaged over the ring entries lo..hi.
  task automatic queue_gain(int unsigned q, int unsigned lo, int unsigned hi, bit fe,
                            bit use_typed, logic [15:0] typed);
    int unsigned sum;
    int unsigned cnt;
    out_item_t r;
    sum = 0;
    cnt = hi - lo + 1;
    for (int unsigned j = lo; j <= hi; j++) sum += raw_ring[j % RING];
    r.gain = use_typed ? typed : 16'((sum + cnt / 2) / cnt);
    r.bin_index = 10'(q);
    r.frame_end = fe;
    pending_gains.push_back(r);
  endtask

  // Advance the predictor by one accepted bin and queue the gains it releases.
  task automatic predict_bin(in_item_t it, bit use_typed, logic [15:0] typed);
    int unsigned p;
    int unsigned h;
    int unsigned wf;
    int unsigned q;
    logic [23:0] m;
    bit refresh;
    bit ends;
    p = bin_pos;
    if (p >= BINS) p = 0;
    if (p == 0) half_w = (smooth_r > 33 ? 33 : smooth_r) / 2;
    h = half_w;
    wf = window_r > 1024 ? 1024 : window_r;
    refresh = (frame_cnt + 1) >= wf;
    m = min_mem[p] < it.magnitude ? min_mem[p] : it.magnitude;
    if (refresh) begin
      floor_mem[p] = m;
      min_mem[p] = it.magnitude;
    end else begin
      min_mem[p] = m;
    end
    raw_ring[p % RING] = raw_gain(it.magnitude, floor_mem[p]);
    ends = it.last_bin || p == BINS - 1;
    if (p >= h) begin
      q = p - h;
      queue_gain(q, q >= h ? q - h : 0, p, ends && h == 0, use_typed, typed);
    end
    if (ends) begin
      // Flush the bins still held back by the smoothing lag.
      for (q = (p >= h ? p - h + 1 : 0); q <= p; q++)
        queue_gain(q, q >= h ? q - h : 0, p, q == p, 0, '0);
      bin_pos = 0;
      frame_cnt = refresh ? 0 : ((frame_cnt + 1) & 10'h3ff);
    end else begin
      bin_pos = p + 1;
    end
  endtask

  // One bin transfer. Valid is only lowered when an idle gap is drawn, so a
  // back-to-back transfer never sees a second assignment in the same step.
  task automatic send_bin(in_item_t it, bit use_typed, logic [15:0] typed);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_bin(it, use_typed, typed);
  endtask

  // Let every expected gain drain, then wait out a bin that yields no gain.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_AMOUNT:  amount_r = val & 24'h1ffff;
      REG_WINDOW:  window_r = val & 24'h7ff;
      REG_SMOOTH:  smooth_r = val & 24'h3f;
      REG_SILENCE: silence_r = val;
      default: ;
    endcase
  endtask

  // Result side: draw a stall length per transfer, then check the transfer
  // against the oldest queued gain.
  initial begin
    int k;
    out_item_t want;
    out_stall = 1'b0;
    forever begin
      k = calm ? 0 : $urandom_range(0, 4);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (pending_gains.size() == 0) begin
        $error("unexpected gain transfer: bin_index %0d gain %0d",
               out_data.bin_index, out_data.gain);
        errors++;
      end else begin
        want = pending_gains.pop_front();
        if (out_data.gain !== want.gain) begin
          $error("gain: expected %0d, actual %0d", want.gain, out_data.gain);
          errors++;
        end
        if (out_data.bin_index !== want.bin_index) begin
          $error("bin_index: expected %0d, actual %0d", want.bin_index, out_data.bin_index);
          errors++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", want.frame_end, out_data.frame_end);
          errors++;
        end
      end
    end
  end

  // Directed table. Register rows are applied with the block idle; bin rows
  // carry a typed gain only where it is obvious (smoothing off, floor zero).
  typedef struct {
    bit is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [23:0] val;
    logic [23:0] mag;
    bit last;
    bit typed;
    logic [15:0] gain;
  } step_t;

  localparam int NSTEPS = 28;
  step_t steps [NSTEPS] = '{
    '{1, REG_SMOOTH, 24'd1, 0, 0, 0, 0},
    '{1, REG_SILENCE, 24'd0, 0, 0, 0, 0},
    // Zero magnitude gets no gain even with the silence level at zero.
    '{0, REG_AMOUNT, 0, 24'h000000, 0, 1, 16'h0000},
    '{0, REG_AMOUNT, 0, 24'hffffff, 0, 1, UNITY},
    '{0, REG_AMOUNT, 0, 24'h000001, 0, 1, UNITY},
    '{0, REG_AMOUNT, 0, 24'h555555, 1, 1, UNITY},
    // A window of zero behaves as one: the floor refreshes every frame.
    '{1, REG_WINDOW, 24'd0, 0, 0, 0, 0},
    '{1, REG_AMOUNT, 24'd0, 0, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'haaaaaa, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h000001, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'hffffff, 1, 0, 0},
    // Amount at 65536, window and smoothing past their ranges, and every
    // magnitude but full scale below the full-scale silence level.
    '{1, REG_AMOUNT, 24'd65536, 0, 0, 0, 0},
    '{1, REG_SILENCE, 24'hffffff, 0, 0, 0, 0},
    '{1, REG_WINDOW, 24'd2047, 0, 0, 0, 0},
    '{1, REG_SMOOTH, 24'd63, 0, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h123456, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'hfffffe, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'hffffff, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h000000, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h800000, 1, 0, 0},
    '{1, REG_SILENCE, 24'd1, 0, 0, 0, 0},
    '{1, REG_SMOOTH, 24'd5, 0, 0, 0, 0},
    '{1, REG_WINDOW, 24'd1024, 0, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h7fffff, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h000001, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h000400, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'h0f0f0f, 0, 0, 0},
    '{0, REG_AMOUNT, 0, 24'hffffff, 1, 0, 0}
  };

  initial begin
    in_item_t it;
    int unsigned level;
    int left;
    int frame_len;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        drain();
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        it.magnitude = steps[i].mag;
        it.last_bin = steps[i].last;
        send_bin(it, steps[i].typed, steps[i].gain);
      end
    end

    // Random phases. Each draws a fresh setting, then frames of noise-like
    // magnitudes around one level so the floor tracking has something to find.
    for (int ph = 0; ph < 11; ph++) begin
      drain();
      calm = (ph % 4 == 3);
      case ($urandom_range(0, 3))
        0: write_reg(REG_AMOUNT, 24'd0);
        1: write_reg(REG_AMOUNT, 24'd65536);
        default: write_reg(REG_AMOUNT, 24'($urandom_range(0, 65536)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_WINDOW, 24'd0);
        1: write_reg(REG_WINDOW, 24'd2047);
        2: write_reg(REG_WINDOW, 24'($urandom_range(1025, 2047)));
        default: write_reg(REG_WINDOW, 24'($urandom_range(1, 4)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_SMOOTH, 24'd33);
        1: write_reg(REG_SMOOTH, 24'($urandom_range(34, 63)));
        2: write_reg(REG_SMOOTH, 24'($urandom_range(0, 1)));
        default: write_reg(REG_SMOOTH, 24'($urandom_range(2, 12)));
      endcase
      level = 1 << $urandom_range(0, 22);
      case ($urandom_range(0, 4))
        0: write_reg(REG_SILENCE, 24'd0);
        1: write_reg(REG_SILENCE, 24'(level));
        default: write_reg(REG_SILENCE, 24'($urandom_range(0, 3)));
      endcase

      left = 20;
      while (left > 0) begin
        frame_len = $urandom_range(1, 12);
        if (frame_len > left) frame_len = left;
        for (int b = 0; b < frame_len; b++) begin
          case ($urandom_range(0, 9))
            0: it.magnitude = 24'd0;
            1: it.magnitude = 24'hffffff;
            2: it.magnitude = 24'($urandom);
            default: it.magnitude = 24'(level + $urandom_range(0, level));
          endcase
          it.last_bin = (b == frame_len - 1);
          send_bin(it, 0, '0);
        end
        left -= frame_len;
      end
    end

    in_valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS spectral_subtraction_mask");
    end else begin
      $display("FAIL spectral_subtraction_mask");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50_000_000;
    $display("FAIL spectral_subtraction_mask");
    $finish;
  end

endmodule

/* spectral_subtraction_mask.f */
src/ssm_pkg.sv
src/ssm_ram.sv
src/ssm_div.sv
src/ssm_dp.sv
src/ssm_ctrl.sv
src/spectral_subtraction_mask.sv
sim/testbench.sv
